// File: src/branch_condition_resolver_unit_assert.svh
// ----------------------------------------------------------------------------
// Branch condition resolver assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef BRANCH_CONDITION_RESOLVER_UNIT_ASSERT_SVH
`define BRANCH_CONDITION_RESOLVER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define BCR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("branch resolver assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("branch resolver assertion failed");

`else

`define BCR_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define BCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: src/bcr_pkg.sv
// ----------------------------------------------------------------------------
// Branch condition resolver package
// Beat types, instruction kind codes, cycle costs and the condition test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcr_pkg;

	// Instruction kind codes
	localparam logic [2:0] KIND_BCC  = 3'd0;
	localparam logic [2:0] KIND_BRA  = 3'd1;
	localparam logic [2:0] KIND_BSR  = 3'd2;
	localparam logic [2:0] KIND_DBCC = 3'd3;
	localparam logic [2:0] KIND_SCC  = 3'd4;
	localparam logic [2:0] KIND_NOP  = 3'd5;

	// Condition codes, opcode bits 11..8
	localparam logic [3:0] CC_T  = 4'd0;
	localparam logic [3:0] CC_F  = 4'd1;
	localparam logic [3:0] CC_HI = 4'd2;
	localparam logic [3:0] CC_LS = 4'd3;
	localparam logic [3:0] CC_CC = 4'd4;
	localparam logic [3:0] CC_CS = 4'd5;
	localparam logic [3:0] CC_NE = 4'd6;
	localparam logic [3:0] CC_EQ = 4'd7;
	localparam logic [3:0] CC_VC = 4'd8;
	localparam logic [3:0] CC_VS = 4'd9;
	localparam logic [3:0] CC_PL = 4'd10;
	localparam logic [3:0] CC_MI = 4'd11;
	localparam logic [3:0] CC_GE = 4'd12;
	localparam logic [3:0] CC_LT = 4'd13;
	localparam logic [3:0] CC_GT = 4'd14;
	localparam logic [3:0] CC_LE = 4'd15;

	// Cycle costs
	localparam logic [4:0] CYC_BRANCH      = 5'd10;
	localparam logic [4:0] CYC_BCC_SHORT   = 5'd8;
	localparam logic [4:0] CYC_BCC_WORD    = 5'd12;
	localparam logic [4:0] CYC_BSR         = 5'd18;
	localparam logic [4:0] CYC_DBCC_TRUE   = 5'd12;
	localparam logic [4:0] CYC_DBCC_EXPIRE = 5'd14;
	localparam logic [4:0] CYC_SCC_REG_T   = 5'd6;
	localparam logic [4:0] CYC_SCC_REG_F   = 5'd4;
	localparam logic [4:0] CYC_SCC_MEM     = 5'd8;
	localparam logic [4:0] CYC_NOP         = 5'd4;

	localparam logic [15:0] COUNT_EXPIRED = 16'hffff;
	localparam logic [7:0]  SET_TRUE      = 8'hff;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] opcode;
		logic [15:0] extension;
		logic [31:0] instr_address;
		logic [3:0]  flags;
		logic [15:0] count_word;
		logic [31:0] stack_pointer;
	} item_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        taken;
		logic [15:0] new_count;
		logic        count_write;
		logic        push_write;
		logic [31:0] push_address;
		logic [31:0] push_value;
		logic [7:0]  set_byte;
		logic [4:0]  cycles;
		logic        used_extension;
	} result_t;

	// Evaluate a condition code against N Z V C (bits 3..0)
	function automatic logic cond_holds(input logic [3:0] cond, input logic [3:0] flags);
		logic n, z, v, c, res;
		n = flags[3];
		z = flags[2];
		v = flags[1];
		c = flags[0];
		unique case (cond)
			CC_T:    res = 1'b1;
			CC_F:    res = 1'b0;
			CC_HI:   res = !c && !z;
			CC_LS:   res = c || z;
			CC_CC:   res = !c;
			CC_CS:   res = c;
			CC_NE:   res = !z;
			CC_EQ:   res = z;
			CC_VC:   res = !v;
			CC_VS:   res = v;
			CC_PL:   res = !n;
			CC_MI:   res = n;
			CC_GE:   res = (n == v);
			CC_LT:   res = (n != v);
			CC_GT:   res = !z && (n == v);
			default: res = z || (n != v);
		endcase
		return res;
	endfunction

endpackage

// File: src/bcr_resolve.sv
// ----------------------------------------------------------------------------
// Branch condition resolver datapath
// Combinational resolution of one program-control instruction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcr_resolve (
	input  bcr_pkg::item_t   item,
	output bcr_pkg::result_t result
);
	import bcr_pkg::*;

	logic        holds;
	logic        byte_zero;
	logic        scc_reg_mode;
	logic [31:0] ext_sx;
	logic [31:0] disp;
	logic [31:0] addr_p2;
	logic [31:0] addr_p4;
	logic [31:0] fall;
	logic [31:0] target;
	logic [31:0] db_target;
	logic [15:0] cnt_dec;

	assign holds        = cond_holds(item.opcode[11:8], item.flags);
	assign byte_zero    = (item.opcode[7:0] == 8'h00);
	assign scc_reg_mode = (item.opcode[5:4] == 2'b00);
	assign ext_sx       = {{16{item.extension[15]}}, item.extension};
	assign disp         = byte_zero ? ext_sx : {{24{item.opcode[7]}}, item.opcode[7:0]};
	assign addr_p2      = item.instr_address + 32'd2;
	assign addr_p4      = item.instr_address + 32'd4;
	assign fall         = byte_zero ? addr_p4 : addr_p2;
	assign target       = addr_p2 + disp;
	assign db_target    = addr_p2 + ext_sx;
	assign cnt_dec      = item.count_word - 16'd1;

	always_comb begin
		result                = '0;
		result.next_pc        = addr_p2;
		result.cycles         = CYC_NOP;
		unique case (item.kind)
			KIND_BCC: begin
				result.used_extension = byte_zero;
				if (holds) begin
					result.next_pc = target;
					result.taken   = 1'b1;
					result.cycles  = CYC_BRANCH;
				end else begin
					result.next_pc = fall;
					result.cycles  = byte_zero ? CYC_BCC_WORD : CYC_BCC_SHORT;
				end
			end
			KIND_BRA: begin
				result.used_extension = byte_zero;
				result.next_pc        = target;
				result.taken          = 1'b1;
				result.cycles         = CYC_BRANCH;
			end
			KIND_BSR: begin
				result.used_extension = byte_zero;
				result.push_write     = 1'b1;
				result.push_address   = item.stack_pointer - 32'd4;
				result.push_value     = fall;
				result.next_pc        = target;
				result.taken          = 1'b1;
				result.cycles         = CYC_BSR;
			end
			KIND_DBCC: begin
				result.used_extension = 1'b1;
				if (holds) begin
					result.next_pc = addr_p4;
					result.cycles  = CYC_DBCC_TRUE;
				end else begin
					result.new_count   = cnt_dec;
					result.count_write = 1'b1;
					if (cnt_dec == COUNT_EXPIRED) begin
						result.next_pc = addr_p4;
						result.cycles  = CYC_DBCC_EXPIRE;
					end else begin
						result.next_pc = db_target;
						result.taken   = 1'b1;
						result.cycles  = CYC_BRANCH;
					end
				end
			end
			KIND_SCC: begin
				result.set_byte = holds ? SET_TRUE : 8'h00;
				if (scc_reg_mode) begin
					result.cycles = holds ? CYC_SCC_REG_T : CYC_SCC_REG_F;
				end else begin
					result.cycles = CYC_SCC_MEM;
				end
			end
			default: begin
				// NOP and the unused kind codes keep the defaults above
				result.cycles = CYC_NOP;
			end
		endcase
	end

endmodule

// File: src/branch_condition_resolver_unit.sv
// ----------------------------------------------------------------------------
// Branch condition resolver unit
// Resolves Bcc, BRA, BSR, DBcc, Scc and NOP: next PC, counter, push, cycles.
// ----------------------------------------------------------------------------
// A new instruction beat may be started in every cycle: the path is an input
// register, one pass of condition test, displacement add and decode, then a
// result register. busy is high only in the first cycle after reset is
// released; from then on start is taken at every edge. The result sits on
// the result port for one cycle with done high and cannot be held off, so a
// receiver must capture it on that edge.
`timescale 1ns / 1ps

`include "branch_condition_resolver_unit_assert.svh"

module branch_condition_resolver_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  bcr_pkg::item_t   item,
	output logic             done,
	output bcr_pkg::result_t result
);
	import bcr_pkg::*;

	logic    ready_q;
	logic    accept;
	logic    valid_s1;
	item_t   item_s1;
	result_t res_comb;
	logic    valid_s2;
	result_t result_s2;

	// Come out of reset busy for one cycle, then accept every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
		end else begin
			ready_q <= 1'b1;
		end
	end

	assign busy   = !ready_q;
	assign accept = start && !busy;

	// Stage 1: capture the instruction beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// Condition test, target add and cycle decode in one pass
	bcr_resolve u_resolve (
		.item   (item_s1),
		.result (res_comb)
	);

	// Stage 2: hold the result for its single strobe cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= res_comb;
		end
	end

	assign done   = valid_s2;
	assign result = result_s2;

	// An accepted beat reaches the resolver stage next cycle
	`BCR_ASSERT_NEXT(a_accept_to_s1, clk, arst_n, accept, valid_s1)
	// The resolver stage always produces a strobe next cycle
	`BCR_ASSERT_NEXT(a_s1_to_done, clk, arst_n, valid_s1, done)
	// A push only comes with a taken subroutine branch
	`BCR_ASSERT_SAME(a_push_taken, clk, arst_n, done && result.push_write,
		result.taken && !result.count_write)
	// Counter write-back only from DBcc, which always consumes the extension
	`BCR_ASSERT_SAME(a_count_ext, clk, arst_n, done && result.count_write,
		result.used_extension && !result.push_write)

endmodule

// File: tb/sv/tb_branch_condition_resolver_unit.sv
// ----------------------------------------------------------------------------
// Branch condition resolver unit testbench
// Sends Bcc, BRA, BSR, DBcc, Scc and NOP beats with random gaps. Each accepted
// beat is resolved by an independent predictor, and every done beat is checked
// field by field against the oldest predicted resolution.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_branch_condition_resolver_unit;

	import bcr_pkg::*;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    done;
	result_t result;

	// Predicted resolutions, oldest first
	result_t pending_resolutions[$];
	int      mismatch_count = 0;
	int      items_sent = 0;
	int      quiet_left = 0;

	branch_condition_resolver_unit u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.done  (done),
		.result(result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Condition test against N Z V C, written as flag algebra
	function automatic logic condition_met(input logic [3:0] cc, input logic [3:0] nzvc);
		logic n, z, v, c, sign_ok;
		n = nzvc[3];
		z = nzvc[2];
		v = nzvc[1];
		c = nzvc[0];
		sign_ok = ~(n ^ v);
		case (cc)
			CC_T:    return 1'b1;
			CC_F:    return 1'b0;
			CC_HI:   return ~(c | z);
			CC_LS:   return c | z;
			CC_CC:   return ~c;
			CC_CS:   return c;
			CC_NE:   return ~z;
			CC_EQ:   return z;
			CC_VC:   return ~v;
			CC_VS:   return v;
			CC_PL:   return ~n;
			CC_MI:   return n;
			CC_GE:   return sign_ok;
			CC_LT:   return ~sign_ok;
			CC_GT:   return ~z & sign_ok;
			default: return z | ~sign_ok;
		endcase
	endfunction

	// Work out the full resolution of one instruction beat
	function automatic result_t resolve_branch(input item_t it);
		result_t     r;
		logic        holds;
		logic        word_disp;
		logic [31:0] disp;
		logic [31:0] fall_through;
		logic [31:0] target;
		logic [15:0] decremented;
		r = '0;
		r.next_pc = it.instr_address + 32'd2;
		r.cycles = CYC_NOP;
		holds = condition_met(it.opcode[11:8], it.flags);
		// a zero byte displacement means the extension word holds a word displacement
		word_disp = (it.opcode[7:0] == 8'h00);
		disp = word_disp ? {{16{it.extension[15]}}, it.extension}
			: {{24{it.opcode[7]}}, it.opcode[7:0]};
		fall_through = it.instr_address + (word_disp ? 32'd4 : 32'd2);
		target = it.instr_address + 32'd2 + disp;
		case (it.kind)
			KIND_BCC: begin
				r.used_extension = word_disp;
				if (holds) begin
					r.next_pc = target;
					r.taken = 1'b1;
					r.cycles = CYC_BRANCH;
				end else begin
					r.next_pc = fall_through;
					r.cycles = word_disp ? CYC_BCC_WORD : CYC_BCC_SHORT;
				end
			end
			KIND_BRA: begin
				r.used_extension = word_disp;
				r.next_pc = target;
				r.taken = 1'b1;
				r.cycles = CYC_BRANCH;
			end
			KIND_BSR: begin
				r.used_extension = word_disp;
				r.push_write = 1'b1;
				r.push_address = it.stack_pointer - 32'd4;
				r.push_value = fall_through;
				r.next_pc = target;
				r.taken = 1'b1;
				r.cycles = CYC_BSR;
			end
			KIND_DBCC: begin
				// DBcc always branches by the extension word
				r.used_extension = 1'b1;
				if (holds) begin
					r.next_pc = it.instr_address + 32'd4;
					r.cycles = CYC_DBCC_TRUE;
				end else begin
					decremented = it.count_word - 16'd1;
					r.new_count = decremented;
					r.count_write = 1'b1;
					if (decremented == COUNT_EXPIRED) begin
						r.next_pc = it.instr_address + 32'd4;
						r.cycles = CYC_DBCC_EXPIRE;
					end else begin
						r.next_pc = it.instr_address + 32'd2
							+ {{16{it.extension[15]}}, it.extension};
						r.taken = 1'b1;
						r.cycles = CYC_BRANCH;
					end
				end
			end
			KIND_SCC: begin
				r.set_byte = holds ? SET_TRUE : 8'h00;
				if (it.opcode[5:4] == 2'b00)
					r.cycles = holds ? CYC_SCC_REG_T : CYC_SCC_REG_F;
				else
					r.cycles = CYC_SCC_MEM;
			end
			default: begin
				// NOP and the unused kinds advance by one word
			end
		endcase
		return r;
	endfunction

	task automatic report_field(input string field_name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t: %s mismatch: expected %h, actual %h",
					$realtime, field_name, want, got);
		end
	endtask

	// Check each done beat, then record each accepted beat. Both sample the
	// values from before the edge, so the order inside the step does not matter.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_resolutions.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: result beat with nothing expected: %h",
						$realtime, result);
			end else begin
				want = pending_resolutions.pop_front();
				report_field("next_pc", want.next_pc, result.next_pc);
				report_field("taken", 32'(want.taken), 32'(result.taken));
				report_field("new_count", 32'(want.new_count), 32'(result.new_count));
				report_field("count_write", 32'(want.count_write),
					32'(result.count_write));
				report_field("push_write", 32'(want.push_write),
					32'(result.push_write));
				report_field("push_address", want.push_address, result.push_address);
				report_field("push_value", want.push_value, result.push_value);
				report_field("set_byte", 32'(want.set_byte), 32'(result.set_byte));
				report_field("cycles", 32'(want.cycles), 32'(result.cycles));
				report_field("used_extension", 32'(want.used_extension),
					32'(result.used_extension));
			end
		end
		if (arst_n && start && !busy)
			pending_resolutions.push_back(resolve_branch(item));
	end

	function automatic item_t make_item(input logic [2:0] kind, input logic [15:0] opcode,
		input logic [15:0] extension, input logic [31:0] addr, input logic [3:0] flags,
		input logic [15:0] count_word, input logic [31:0] sp);
		item_t it;
		it.kind = kind;
		it.opcode = opcode;
		it.extension = extension;
		it.instr_address = addr;
		it.flags = flags;
		it.count_word = count_word;
		it.stack_pointer = sp;
		return it;
	endfunction

	// Fill every bit of an instruction beat at random
	function automatic item_t random_bits();
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		return raw[$bits(item_t)-1:0];
	endfunction

	// Mostly back to back or short gaps, a few long ones, and now and then
	// a stretch with no gaps at all
	function automatic int pick_gap();
		int roll;
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 99) == 0) begin
			quiet_left = $urandom_range(20, 60);
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		else if (roll < 88)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 40);
	endfunction

	// Present one beat and hold it until the edge that takes it, then idle
	// for a random gap. start stays high when no gap follows.
	task automatic send_instruction(input item_t it);
		int   gap;
		logic took;
		item <= it;
		start <= 1'b1;
		// busy only moves at the rising edge, so sample it mid-cycle
		do begin
			@(negedge clk);
			took = !busy;
			@(posedge clk);
		end while (!took);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			// drive junk on the item port while start is low
			item <= random_bits();
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic test_branch_displacements();
		// byte displacement extremes, with the address wrapping past the top
		send_instruction(make_item(KIND_BRA, 16'h607f, 16'h1234, 32'hfffffffe, 4'h0,
			16'h0000, 32'h0000_1000));
		send_instruction(make_item(KIND_BRA, 16'h6080, 16'hffff, 32'h0000_0010, 4'hf,
			16'hffff, 32'h0000_1000));
		// byte 0xff is a displacement of -1, not a long form
		send_instruction(make_item(KIND_BRA, 16'h60ff, 16'h0000, 32'h0000_4000, 4'h0,
			16'h0000, 32'h0000_1000));
		send_instruction(make_item(KIND_BRA, 16'h6000, 16'h8000, 32'h0000_0000, 4'h0,
			16'h0000, 32'h0000_1000));
		// push with the stack pointer wrapping below zero, then at the top
		send_instruction(make_item(KIND_BSR, 16'h6101, 16'h0000, 32'h0000_2000, 4'h5,
			16'h0000, 32'h0000_0000));
		send_instruction(make_item(KIND_BSR, 16'h6100, 16'h7fff, 32'hffff_fff0, 4'ha,
			16'hffff, 32'hffff_ffff));
	endtask

	task automatic test_conditional_branches();
		// T always branches, F never does, with both displacement sizes
		send_instruction(make_item(KIND_BCC, {4'h6, CC_T, 8'h10}, 16'h0000,
			32'h0000_1000, 4'h0, 16'h0000, 32'h0));
		send_instruction(make_item(KIND_BCC, {4'h6, CC_F, 8'h10}, 16'h0000,
			32'h0000_1000, 4'hf, 16'h0000, 32'h0));
		send_instruction(make_item(KIND_BCC, {4'h6, CC_F, 8'h00}, 16'h0100,
			32'h0000_1000, 4'hf, 16'h0000, 32'h0));
		send_instruction(make_item(KIND_BCC, {4'h6, CC_EQ, 8'h00}, 16'hfffe,
			32'h0000_1000, 4'h4, 16'h0000, 32'h0));
	endtask

	task automatic test_dbcc_loop();
		// condition true drops out without touching the counter
		send_instruction(make_item(KIND_DBCC, {4'h5, CC_T, 8'hc8}, 16'hfff0,
			32'h0000_3000, 4'h0, 16'h0005, 32'h0));
		// counter 0 expires to 0xffff, counter 1 still branches on 0
		send_instruction(make_item(KIND_DBCC, {4'h5, CC_F, 8'hc8}, 16'hfff0,
			32'h0000_3000, 4'h0, 16'h0000, 32'h0));
		send_instruction(make_item(KIND_DBCC, {4'h5, CC_F, 8'hc8}, 16'hfff0,
			32'h0000_3000, 4'h0, 16'h0001, 32'h0));
		send_instruction(make_item(KIND_DBCC, {4'h5, CC_NE, 8'hc8}, 16'h7fff,
			32'hffff_fffe, 4'h4, 16'hffff, 32'h0));
	endtask

	task automatic test_scc_modes();
		// register mode true and false, then two memory modes
		send_instruction(make_item(KIND_SCC, {4'h5, CC_T, 8'hc3}, 16'h0000,
			32'h0000_5000, 4'h0, 16'h0000, 32'h0));
		send_instruction(make_item(KIND_SCC, {4'h5, CC_F, 8'hc3}, 16'h0000,
			32'h0000_5000, 4'h0, 16'h0000, 32'h0));
		send_instruction(make_item(KIND_SCC, {4'h5, CC_MI, 8'hd0}, 16'hffff,
			32'h0000_5000, 4'h8, 16'h0000, 32'h0));
		send_instruction(make_item(KIND_SCC, {4'h5, CC_MI, 8'hf8}, 16'hffff,
			32'h0000_5000, 4'h0, 16'h0000, 32'h0));
	endtask

	task automatic test_nop_and_unused_kinds();
		send_instruction(make_item(KIND_NOP, 16'h4e71, 16'hffff, 32'hffff_fffe, 4'hf,
			16'hffff, 32'hffff_ffff));
		send_instruction(make_item(3'd6, 16'hffff, 16'hffff, 32'h0000_0000, 4'hf,
			16'h0000, 32'h0000_0000));
		send_instruction(make_item(3'd7, 16'h6000, 16'h8000, 32'h8000_0000, 4'h0,
			16'h0001, 32'h0000_0004));
	endtask

	function automatic item_t random_instruction();
		item_t it;
		int    roll;
		it = random_bits();
		roll = $urandom_range(0, 99);
		it.kind = (roll < 94) ? 3'($urandom_range(0, 5)) : 3'($urandom_range(6, 7));
		// steer toward the word displacement and the register form of Scc
		if ($urandom_range(0, 3) == 0)
			it.opcode[7:0] = 8'h00;
		if ($urandom_range(0, 2) == 0)
			it.opcode[5:4] = 2'b00;
		case ($urandom_range(0, 11))
			0: it.count_word = 16'h0000;
			1: it.count_word = 16'h0001;
			2: it.count_word = 16'hffff;
			default: ;
		endcase
		return it;
	endfunction

	// Run a DBcc loop the way a program would: same instruction, counter fed back
	// from the previous pass, until it falls through, expires or reaches ten passes
	task automatic run_dbcc_loop();
		item_t       it;
		logic [15:0] counter;
		int          passes;
		it = random_instruction();
		it.kind = KIND_DBCC;
		it.extension = 16'($urandom_range(0, 200)) ^ 16'hffff;
		counter = 16'($urandom_range(0, 6));
		passes = 0;
		while (passes < 10) begin
			it.count_word = counter;
			// usually keep the loop going with a false condition
			it.flags = 4'($urandom);
			if ($urandom_range(0, 7) != 0)
				it.opcode[11:8] = CC_F;
			else
				it.opcode[11:8] = 4'($urandom);
			send_instruction(it);
			passes++;
			if (condition_met(it.opcode[11:8], it.flags) || counter == 16'h0000)
				break;
			counter = counter - 16'd1;
		end
	endtask

	task automatic test_random_mix(input int target_items);
		while (items_sent < target_items) begin
			if ($urandom_range(0, 19) == 0)
				run_dbcc_loop();
			else
				send_instruction(random_instruction());
		end
	endtask

	initial begin
		start <= 1'b0;
		item <= '0;
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		test_branch_displacements();
		test_conditional_branches();
		test_dbcc_loop();
		test_scc_modes();
		test_nop_and_unused_kinds();
		test_random_mix(1275);

		// drop start and drain the input and result registers
		start <= 1'b0;
		while (pending_resolutions.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_branch_condition_resolver_unit: done, clean");
		else
			$display("tb_branch_condition_resolver_unit: done, errors");
		$finish;
	end

	// Hard stop well past the slowest correct run
	initial begin
		#1000000;
		$display("tb_branch_condition_resolver_unit: done, errors");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+src
src/bcr_pkg.sv
src/bcr_resolve.sv
src/branch_condition_resolver_unit.sv
tb/sv/tb_branch_condition_resolver_unit.sv
